/* sv/pli_pkg.sv */
// Shared types, constants and codes for the piecewise linear interpolation table.
package pli_pkg;

   localparam int MAX_POINTS = 16;
   localparam int VALUE_BITS = 16;

   localparam int IDX_BITS  = $clog2(MAX_POINTS);
   localparam int CNT_BITS  = $clog2(MAX_POINTS + 1);
   localparam int DIST_BITS = VALUE_BITS + 1;
   localparam int PROD_BITS = 2 * VALUE_BITS + 2;
   localparam int MAG_BITS  = 2 * VALUE_BITS;
   localparam int DIV_CNT_BITS = $clog2(MAG_BITS);

   localparam logic [1:0] OP_SET   = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]                   operation;
      logic signed [VALUE_BITS-1:0] point_x;
      logic signed [VALUE_BITS-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] result_value;
      logic [1:0]                   status;
   } rsp_type;

   typedef struct packed {
      logic                         en;
      logic [IDX_BITS-1:0]          addr;
      logic signed [VALUE_BITS-1:0] key;
      logic signed [VALUE_BITS-1:0] value;
   } tbl_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DIV
   } state_type;

endpackage

/* sv/pli_table.sv */
// Breakpoint storage: key and value memories, one write port, one registered read port.
module pli_table (
   input  logic                             clock,
   input  pli_pkg::tbl_wr_type              wr,
   input  logic [pli_pkg::IDX_BITS-1:0]     rd_addr,
   output logic signed [pli_pkg::VALUE_BITS-1:0] rd_key,
   output logic signed [pli_pkg::VALUE_BITS-1:0] rd_value
);
   import pli_pkg::*;

   logic signed [VALUE_BITS-1:0] key_mem [MAX_POINTS];
   logic signed [VALUE_BITS-1:0] val_mem [MAX_POINTS];
   logic signed [VALUE_BITS-1:0] rd_key_ff;
   logic signed [VALUE_BITS-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr.addr] <= wr.key;
         val_mem[wr.addr] <= wr.value;
      end
      rd_key_ff   <= key_mem[rd_addr];
      rd_value_ff <= val_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule

/* sv/pli_divider.sv */
// Restoring serial divider, one quotient bit per cycle, truncates toward zero.
module pli_divider (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [pli_pkg::PROD_BITS-1:0]  num,
   input  logic [pli_pkg::DIST_BITS-1:0]         den,
   output logic                                  done,
   output logic signed [pli_pkg::VALUE_BITS-1:0] quotient
);
   import pli_pkg::*;

   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [DIV_CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                         neg_ff, neg_in;
   logic [DIST_BITS-1:0]         den_ff, den_in;
   logic [DIST_BITS-1:0]         rem_ff, rem_in;
   logic [MAG_BITS-1:0]          quo_ff, quo_in;
   logic signed [VALUE_BITS-1:0] res_ff, res_in;

   logic [PROD_BITS-1:0]         num_abs;
   logic [DIST_BITS:0]           rem_sh;
   logic [DIST_BITS:0]           rem_diff;
   logic                         ge;
   logic [MAG_BITS-1:0]          quo_step;
   logic [VALUE_BITS-1:0]        q_mag;

   assign num_abs  = num[PROD_BITS-1] ? PROD_BITS'(-num) : PROD_BITS'(num);
   assign rem_sh   = {rem_ff, quo_ff[MAG_BITS-1]};
   assign ge       = rem_sh >= {1'b0, den_ff};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign quo_step = {quo_ff[MAG_BITS-2:0], ge};
   assign q_mag    = quo_step[VALUE_BITS-1:0];

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      res_in  = res_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         neg_in = num[PROD_BITS-1];
         den_in = den;
         rem_in = '0;
         quo_in = num_abs[MAG_BITS-1:0];
      end else if (run_ff) begin
         rem_in = ge ? rem_diff[DIST_BITS-1:0] : rem_sh[DIST_BITS-1:0];
         quo_in = quo_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(MAG_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? $signed(-q_mag) : $signed(q_mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      res_ff <= res_in;
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

/* sv/piecewise_linear_interpolator_top.sv */
// Top level of the piecewise linear interpolation table: sequencer, scan, multiply and divide.
//
// Command channel: an item is taken when start is high and busy is low. The item
// carries an operation (set, query, clear) with an x and a y in signed Q8.8.
// Each item produces exactly one result beat on rsp_data, marked by rsp_valid
// for a single cycle; the receiver cannot hold it off.
// Set scans the stored breakpoints one per cycle through the table's registered
// read port, then updates the matching entry or appends if the table is not full.
// Query scans the same way and stops early on an exact key match; a clamp
// result also comes out at the end of the scan. A query between two breakpoints
// then passes through the shared multiplier (ST_MUL_LO, ST_MUL_HI) and the
// bit-serial divider. Clear, an unused operation and a query on an empty table
// answer in the cycle after they are taken, without a scan; busy stays low for them.
// For the other items busy stays high for the whole item; the next item may start
// in the cycle the result beat is shown.
// Reset empties the table (point count to zero) and idles the sequencer; the
// breakpoint memories are not cleared since only entries below the count are read.
module piecewise_linear_interpolator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pli_pkg::req_type req_data,
   output logic             rsp_valid,
   output pli_pkg::rsp_type rsp_data
);
   import pli_pkg::*;

   state_type                    state_ff, state_in;
   req_type                      req_ff, req_in;
   logic [CNT_BITS-1:0]          used_ff, used_in;
   logic [CNT_BITS-1:0]          addr_ff, addr_in;
   logic                         pend_ff, pend_in;
   logic [IDX_BITS-1:0]          pend_idx_ff, pend_idx_in;
   logic                         has_lo_ff, has_lo_in;
   logic                         has_hi_ff, has_hi_in;
   logic signed [VALUE_BITS-1:0] xl_ff, xl_in;
   logic signed [VALUE_BITS-1:0] yl_ff, yl_in;
   logic signed [VALUE_BITS-1:0] xh_ff, xh_in;
   logic signed [VALUE_BITS-1:0] yh_ff, yh_in;
   logic signed [PROD_BITS-1:0]  acc_ff, acc_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;

   tbl_wr_type                   tbl_wr;
   logic signed [VALUE_BITS-1:0] rd_key;
   logic signed [VALUE_BITS-1:0] rd_value;

   logic                         accept;
   logic                         key_eq;
   logic                         scan_done;
   logic [DIST_BITS-1:0]         d_hi;
   logic [DIST_BITS-1:0]         d_lo;
   logic [DIST_BITS-1:0]         den;
   logic signed [PROD_BITS-1:0]  mul_a;
   logic signed [PROD_BITS-1:0]  mul_b;
   logic signed [PROD_BITS-1:0]  product;
   logic signed [PROD_BITS-1:0]  num_sum;
   logic                         div_start;
   logic                         div_done;
   logic signed [VALUE_BITS-1:0] div_q;

   assign busy      = state_ff != ST_IDLE;
   assign accept    = start && !busy;
   assign key_eq    = pend_ff && (rd_key == req_ff.point_x);
   assign scan_done = !pend_ff && (addr_ff == used_ff);

   // distances are never negative, so the 17-bit differences read as unsigned
   assign d_hi = DIST_BITS'({xh_ff[VALUE_BITS-1], xh_ff})
               - DIST_BITS'({req_ff.point_x[VALUE_BITS-1], req_ff.point_x});
   assign d_lo = DIST_BITS'({req_ff.point_x[VALUE_BITS-1], req_ff.point_x})
               - DIST_BITS'({xl_ff[VALUE_BITS-1], xl_ff});
   assign den  = DIST_BITS'({xh_ff[VALUE_BITS-1], xh_ff})
               - DIST_BITS'({xl_ff[VALUE_BITS-1], xl_ff});

   // shared multiplier: y_lo*(x_hi-x) first, then y_hi*(x-x_lo)
   always_comb begin
      if (state_ff == ST_MUL_LO) begin
         mul_a = PROD_BITS'(yl_ff);
         mul_b = $signed(PROD_BITS'(d_hi));
      end else begin
         mul_a = PROD_BITS'(yh_ff);
         mul_b = $signed(PROD_BITS'(d_lo));
      end
   end

   assign product   = mul_a * mul_b;
   assign num_sum   = acc_ff + product;
   assign div_start = state_ff == ST_MUL_HI;

   pli_table u_table (
      .clock    (clock),
      .wr       (tbl_wr),
      .rd_addr  (addr_ff[IDX_BITS-1:0]),
      .rd_key   (rd_key),
      .rd_value (rd_value)
   );

   pli_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_sum),
      .den      (den),
      .done     (div_done),
      .quotient (div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.operation == OP_SET) begin
                  state_in = ST_SCAN;
               end else if (req_data.operation == OP_QUERY && used_ff != '0) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (key_eq) begin
               state_in = ST_IDLE;
            end else if (scan_done) begin
               if (req_ff.operation == OP_QUERY && has_lo_ff && has_hi_ff) begin
                  state_in = ST_MUL_LO;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in       = req_ff;
      used_in      = used_ff;
      addr_in      = addr_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      has_lo_in    = has_lo_ff;
      has_hi_in    = has_hi_ff;
      xl_in        = xl_ff;
      yl_in        = yl_ff;
      xh_in        = xh_ff;
      yh_in        = yh_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      tbl_wr.en    = 1'b0;
      tbl_wr.addr  = pend_idx_ff;
      tbl_wr.key   = req_ff.point_x;
      tbl_wr.value = req_ff.point_y;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in    = req_data;
               addr_in   = '0;
               pend_in   = 1'b0;
               has_lo_in = 1'b0;
               has_hi_in = 1'b0;
               if (req_data.operation == OP_CLEAR) begin
                  used_in      = '0;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{result_value: '0, status: STATUS_OK};
               end else if (req_data.operation == OP_QUERY) begin
                  if (used_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{result_value: '0, status: STATUS_EMPTY};
                  end
               end else if (req_data.operation != OP_SET) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{result_value: '0, status: STATUS_OK};
               end
            end
         end
         ST_SCAN: begin
            // issue the next read; its data is evaluated in the following cycle
            if (addr_ff < used_ff) begin
               addr_in     = addr_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = addr_ff[IDX_BITS-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (key_eq) begin
               rsp_valid_in = 1'b1;
               if (req_ff.operation == OP_SET) begin
                  tbl_wr.en = 1'b1;
                  rsp_in    = '{result_value: '0, status: STATUS_OK};
               end else begin
                  rsp_in    = '{result_value: rd_value, status: STATUS_OK};
               end
            end else if (pend_ff) begin
               if (req_ff.point_x < rd_key) begin
                  if (!has_hi_ff || rd_key < xh_ff) begin
                     has_hi_in = 1'b1;
                     xh_in     = rd_key;
                     yh_in     = rd_value;
                  end
               end else begin
                  if (!has_lo_ff || rd_key > xl_ff) begin
                     has_lo_in = 1'b1;
                     xl_in     = rd_key;
                     yl_in     = rd_value;
                  end
               end
            end else if (scan_done) begin
               if (req_ff.operation == OP_SET) begin
                  rsp_valid_in = 1'b1;
                  if (used_ff == CNT_BITS'(MAX_POINTS)) begin
                     rsp_in = '{result_value: '0, status: STATUS_FULL};
                  end else begin
                     tbl_wr.en   = 1'b1;
                     tbl_wr.addr = used_ff[IDX_BITS-1:0];
                     used_in     = used_ff + 1'b1;
                     rsp_in      = '{result_value: '0, status: STATUS_OK};
                  end
               end else if (!has_hi_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{result_value: yl_ff, status: STATUS_OK};
               end else if (!has_lo_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{result_value: yh_ff, status: STATUS_OK};
               end
            end
         end
         ST_MUL_LO: begin
            acc_in = product;
         end
         ST_MUL_HI: begin
            acc_in = num_sum;
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{result_value: div_q, status: STATUS_OK};
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         has_lo_ff    <= 1'b0;
         has_hi_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         has_lo_ff    <= has_lo_in;
         has_hi_ff    <= has_hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pend_idx_ff <= pend_idx_in;
      xl_ff       <= xl_in;
      yl_ff       <= yl_in;
      xh_ff       <= xh_in;
      yh_ff       <= yh_in;
      acc_ff      <= acc_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* bench/pli_table_checker.sv */
// Checker for the interpolation table: watches both channels, predicts each result beat and compares.
module pli_table_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  pli_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  pli_pkg::rsp_type rsp_data,
   output int               mismatches,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import pli_pkg::*;

   logic signed [VALUE_BITS-1:0] bp_x [MAX_POINTS];
   logic signed [VALUE_BITS-1:0] bp_y [MAX_POINTS];
   int point_count = 0;

   rsp_type expected_rsp_q [$];
   int error_total   = 0;
   int pending_beats = 0;

   assign mismatches  = error_total;
   assign outstanding = pending_beats;

   // Updates the table model and returns the result this item must produce.
   function automatic rsp_type apply_table_op(input req_type item);
      rsp_type out;
      logic    found;
      logic    has_lo;
      logic    has_hi;
      longint  x, k, xl, yl, xh, yh, dlo, dhi;
      out    = '0;
      found  = 1'b0;
      has_lo = 1'b0;
      has_hi = 1'b0;
      xl = 0; yl = 0; xh = 0; yh = 0;
      case (item.operation)
         OP_SET: begin
            for (int i = 0; i < point_count; i++) begin
               if (!found && bp_x[i] == item.point_x) begin
                  bp_y[i] = item.point_y;
                  found   = 1'b1;
               end
            end
            if (!found) begin
               if (point_count >= MAX_POINTS) begin
                  out.status = STATUS_FULL;
               end else begin
                  bp_x[point_count] = item.point_x;
                  bp_y[point_count] = item.point_y;
                  point_count++;
               end
            end
         end
         OP_QUERY: begin
            if (point_count == 0) begin
               out.status = STATUS_EMPTY;
            end else begin
               x = item.point_x;
               for (int i = 0; i < point_count; i++) begin
                  k = bp_x[i];
                  if (!found) begin
                     if (k == x) begin
                        found = 1'b1;
                        out.result_value = bp_y[i];
                     end else if (x < k) begin
                        if (!has_hi || k < xh) begin
                           has_hi = 1'b1; xh = k; yh = bp_y[i];
                        end
                     end else begin
                        if (!has_lo || k > xl) begin
                           has_lo = 1'b1; xl = k; yl = bp_y[i];
                        end
                     end
                  end
               end
               if (!found) begin
                  if (!has_hi) begin
                     out.result_value = yl[VALUE_BITS-1:0];
                  end else if (!has_lo) begin
                     out.result_value = yh[VALUE_BITS-1:0];
                  end else begin
                     dlo = x - xl;
                     dhi = xh - x;
                     // signed longint division truncates toward zero
                     k = (yl * dhi + yh * dlo) / (dlo + dhi);
                     out.result_value = k[VALUE_BITS-1:0];
                  end
               end
            end
         end
         OP_CLEAR: begin
            point_count = 0;
         end
         default: begin
         end
      endcase
      return out;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         point_count = 0;
         expected_rsp_q.delete();
      end else begin
         // a result beat here always belongs to an earlier item
         if (rsp_valid) begin
            if (expected_rsp_q.size() == 0) begin
               error_total++;
               $display("%0t: unexpected result beat: expected none, actual value %0d status %0d",
                        $time, rsp_data.result_value, rsp_data.status);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.result_value !== want.result_value) begin
                  error_total++;
                  $display("%0t: result_value mismatch: expected %0d, actual %0d",
                           $time, want.result_value, rsp_data.result_value);
               end
               if (rsp_data.status !== want.status) begin
                  error_total++;
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_data.status);
               end
            end
         end
         if (start && !busy)
            expected_rsp_q.push_back(apply_table_op(req_data));
      end
      pending_beats <= expected_rsp_q.size();
   end

endmodule

/* bench/tb_piecewise_linear_interpolator_top.sv */
// Testbench top for the interpolation table: clock, reset, command stimulus and verdict.
module tb_piecewise_linear_interpolator_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pli_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 2000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      mismatches;
   int      outstanding;

   logic signed [VALUE_BITS-1:0] known_x [$];
   int items_sent = 0;
   bit steady_run = 1'b0;

   piecewise_linear_interpolator_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   pli_table_checker table_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_run || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] rand_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         case ($urandom_range(0, 4))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return -16'sd1;
            default: return 16'sd1;
         endcase
      end
      // clustered values give neighbors and repeated keys
      if (r < 50)
         return 16'($urandom_range(0, 511)) - 16'd256;
      return 16'($urandom);
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] query_x();
      int r;
      logic signed [VALUE_BITS-1:0] base;
      r = $urandom_range(0, 99);
      if (known_x.size() == 0 || r >= 50)
         return rand_value();
      base = known_x[$urandom_range(0, known_x.size() - 1)];
      if (r < 35)
         return base;
      return ($urandom_range(0, 1) != 0) ? base + 16'sd1 : base - 16'sd1;
   endfunction

   task automatic send_beat(input logic [1:0] op, input logic signed [VALUE_BITS-1:0] x,
                            input logic signed [VALUE_BITS-1:0] y);
      req_type item;
      req_type noise;
      int      gap;
      item.operation = op;
      item.point_x   = x;
      item.point_y   = y;
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (op != OP_UNUSED)
         items_sent++;
      if (op == OP_CLEAR)
         known_x.delete();
      else if (op == OP_SET)
         known_x.push_back(x);
      gap = pick_gap();
      if (gap > 0) begin
         noise.operation = 2'($urandom_range(0, 3));
         noise.point_x   = 16'($urandom);
         noise.point_y   = 16'($urandom);
         start    <= 1'b0;
         req_data <= noise;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int n_sets;
      int n_queries;
      int episode;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extreme keys, update, unused op, clamps, interpolation
      send_beat(OP_QUERY, 16'sh8000, 16'sh7fff);
      send_beat(OP_QUERY, 16'sh7fff, 16'sh8000);
      send_beat(OP_SET,   16'sh8000, 16'sh7fff);
      send_beat(OP_SET,   16'sh7fff, 16'sh8000);
      send_beat(OP_QUERY, 16'sd0,    16'sd0);
      send_beat(OP_QUERY, 16'sh8000, 16'sd0);
      send_beat(OP_QUERY, 16'sh7fff, 16'sd0);
      send_beat(OP_SET,   16'sd0,    16'sh8000);
      send_beat(OP_SET,   16'sd0,    16'sd100);
      send_beat(OP_QUERY, -16'sd1,   16'sd0);
      send_beat(OP_QUERY, 16'sd1,    16'sd0);
      send_beat(OP_UNUSED, -16'sd1,  -16'sd1);
      send_beat(OP_CLEAR, 16'sd0,    16'sd0);
      send_beat(OP_QUERY, 16'sd5,    16'sd0);
      send_beat(OP_SET,   16'sd100,  -16'sd5);
      send_beat(OP_SET,   16'sd200,  16'sd2);
      send_beat(OP_QUERY, 16'sd50,   16'sd0);
      send_beat(OP_QUERY, 16'sd300,  16'sd0);
      // negative quotient, truncated toward zero
      send_beat(OP_QUERY, 16'sd130,  16'sd0);
      send_beat(OP_QUERY, 16'sd200,  16'sd0);
      send_beat(OP_CLEAR, 16'sd0,    16'sd0);
      wait_for_results();

      items_sent = 0;
      episode = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) != 0)
            send_beat(OP_CLEAR, rand_value(), rand_value());
         // often enough past MAX_POINTS to hit the full-table case
         n_sets = $urandom_range(0, 21);
         for (int i = 0; i < n_sets; i++) begin
            if (known_x.size() != 0 && $urandom_range(0, 4) == 0)
               send_beat(OP_SET, known_x[$urandom_range(0, known_x.size() - 1)], rand_value());
            else
               send_beat(OP_SET, rand_value(), rand_value());
         end
         n_queries = $urandom_range(4, 24);
         for (int i = 0; i < n_queries; i++) begin
            if ($urandom_range(0, 19) == 0)
               send_beat(2'($urandom_range(0, 3)), rand_value(), rand_value());
            else
               send_beat(OP_QUERY, query_x(), rand_value());
         end
         episode++;
         if ($urandom_range(0, 4) == 0)
            steady_run = ~steady_run;
         if (episode % 8 == 0)
            wait_for_results();
      end

      wait_for_results();
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
